/* rtl/core/clex_pkg.sv */
package clex_pkg;

  localparam int NAME_CAPACITY_DEF = 31;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int KW_P_W  = 6;
  localparam int KW_N    = 4;

  typedef enum logic [4:0] {
    KIND_INTEGER   = 5'd0,
    KIND_IDENT     = 5'd1,
    KIND_KW_INT    = 5'd2,
    KIND_KW_RETURN = 5'd3,
    KIND_KW_IF     = 5'd4,
    KIND_KW_ELSE   = 5'd5,
    KIND_ASSIGN    = 5'd6,
    KIND_PLUS      = 5'd7,
    KIND_MINUS     = 5'd8,
    KIND_STAR      = 5'd9,
    KIND_SLASH     = 5'd10,
    KIND_LPAREN    = 5'd11,
    KIND_RPAREN    = 5'd12,
    KIND_LBRACE    = 5'd13,
    KIND_RBRACE    = 5'd14,
    KIND_SEMI      = 5'd15,
    KIND_EOF       = 5'd16,
    KIND_UNKNOWN   = 5'd17
  } kind_e;

  // keyword slots in the match vector
  localparam int KW_INT    = 0;
  localparam int KW_RETURN = 1;
  localparam int KW_IF     = 2;
  localparam int KW_ELSE   = 3;

  // one queue entry: an optional pending token closed by the byte, then the byte's own token
  typedef struct packed {
    logic                      has_flush;
    logic                      flush_ident;
    kind_e                     flush_kind;
    logic [VALUE_W-1:0]        flush_value;
    logic                      has_own;
    kind_e                     own_kind;
  } cmd_t;

  typedef struct packed {
    logic                      last_result;
    logic                      text_end;
    logic [POS_W-1:0]          text_position;
    logic [CHAR_W-1:0]         text_char;
    logic signed [VALUE_W-1:0] int_value;
    kind_e                     token_kind;
  } result_t;

  function automatic logic is_digit(logic [CHAR_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_name_start(logic [CHAR_W-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_name_char(logic [CHAR_W-1:0] c);
    return is_name_start(c) || is_digit(c);
  endfunction

  function automatic logic is_space(logic [CHAR_W-1:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic kind_e symbol_kind(logic [CHAR_W-1:0] c);
    kind_e k;
    unique case (c)
      "=":     k = KIND_ASSIGN;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ";":     k = KIND_SEMI;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // per-keyword match of character c at position p
  function automatic logic [KW_N-1:0] kw_step(logic [CHAR_W-1:0] c, logic [KW_P_W-1:0] p);
    logic [KW_N-1:0] m;
    m = '0;
    unique case (p)
      6'd0: begin
        m[KW_INT]    = (c == "i");
        m[KW_RETURN] = (c == "r");
        m[KW_IF]     = (c == "i");
        m[KW_ELSE]   = (c == "e");
      end
      6'd1: begin
        m[KW_INT]    = (c == "n");
        m[KW_RETURN] = (c == "e");
        m[KW_IF]     = (c == "f");
        m[KW_ELSE]   = (c == "l");
      end
      6'd2: begin
        m[KW_INT]    = (c == "t");
        m[KW_RETURN] = (c == "t");
        m[KW_ELSE]   = (c == "s");
      end
      6'd3: begin
        m[KW_RETURN] = (c == "u");
        m[KW_ELSE]   = (c == "e");
      end
      6'd4: m[KW_RETURN] = (c == "r");
      6'd5: m[KW_RETURN] = (c == "n");
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/c_subset_token_lexer_top.sv */
// Lexer for a small C subset: one source byte per input word, byte 0 ends the text.
// The front end takes one byte per cycle and queues at most one entry per byte
// (a token closed by the byte plus the byte's own token); the back end sends one
// result word per cycle, while the receiver is ready, through an output register.
// An identifier of n stored characters leaves as n result words, one name-buffer
// read each. Since the name buffer is single-ported per side, a byte that starts
// a new name is held until every earlier identifier run has left the back end;
// the front also waits when the command queue is full.
module c_subset_token_lexer_top #(
  parameter int NAME_CAPACITY = clex_pkg::NAME_CAPACITY_DEF,
  parameter int QUEUE_DEPTH   = clex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // token_kind, int_value, text_char, text_position, text_end
  output logic        m_axis_tlast   // last_result
);

  localparam int IDX_W = $clog2(NAME_CAPACITY);
  localparam int LEN_W = $clog2(NAME_CAPACITY + 1);
  localparam int Q_W   = $bits(clex_pkg::cmd_t) + LEN_W;

  clex_pkg::cmd_t              f_cmd, b_cmd;
  logic [LEN_W-1:0]            f_len, b_len;
  logic                        q_push, q_push_ready, q_pop_valid, q_pop;
  logic                        ident_done;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr, rd_addr;
  logic [clex_pkg::CHAR_W-1:0] wr_data, rd_data;
  clex_pkg::result_t           res;

  clex_front #(
    .NAME_CAPACITY (NAME_CAPACITY),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_char_i    (s_axis_tdata),
    .cmd_valid_o  (q_push),
    .cmd_ready_i  (q_push_ready),
    .cmd_o        (f_cmd),
    .cmd_len_o    (f_len),
    .ident_done_i (ident_done),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  clex_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push),
    .push_ready_o (q_push_ready),
    .push_data_i  ({f_len, f_cmd}),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop),
    .pop_data_o   ({b_len, b_cmd})
  );

  clex_ram #(
    .WIDTH (clex_pkg::CHAR_W),
    .DEPTH (NAME_CAPACITY)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  clex_back #(
    .NAME_CAPACITY (NAME_CAPACITY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_pop_valid),
    .cmd_ready_o  (q_pop),
    .cmd_i        (b_cmd),
    .cmd_len_i    (b_len),
    .ident_done_o (ident_done),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tdata = {5'd0, res.text_end, res.text_position, res.text_char,
                         res.int_value, res.token_kind};
  assign m_axis_tlast = res.last_result;

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_push_ready)
    else $error("command pushed into full queue");

  a_pop_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_pop_valid)
    else $error("command popped from empty queue");

  a_eof_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[4:0] == clex_pkg::KIND_EOF)) |-> m_axis_tlast)
    else $error("end-of-file word not marked last");

  a_non_ident_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[4:0] != clex_pkg::KIND_IDENT)) |-> m_axis_tdata[50])
    else $error("non-identifier word without text end");
`endif

endmodule

/* rtl/core/clex_ram.sv */
module clex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/clex_queue.sv */
module clex_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/clex_front.sv */
module clex_front #(
  parameter int NAME_CAPACITY = clex_pkg::NAME_CAPACITY_DEF,
  parameter int QUEUE_DEPTH   = clex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [clex_pkg::CHAR_W-1:0]       in_char_i,
  output logic                              cmd_valid_o,
  input  logic                              cmd_ready_i,
  output clex_pkg::cmd_t                    cmd_o,
  output logic [$clog2(NAME_CAPACITY+1)-1:0] cmd_len_o,
  input  logic                              ident_done_i,
  output logic                              wr_en_o,
  output logic [$clog2(NAME_CAPACITY)-1:0]  wr_addr_o,
  output logic [clex_pkg::CHAR_W-1:0]       wr_data_o
);

  localparam int IDX_W = $clog2(NAME_CAPACITY);
  localparam int LEN_W = $clog2(NAME_CAPACITY + 1);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_NUMBER = 3'b010,
    MODE_NAME   = 3'b100
  } mode_e;

  mode_e                            mode_q, mode_d;
  logic [clex_pkg::VALUE_W-1:0]     acc_q, acc_d;
  logic [LEN_W-1:0]                 len_q, len_d;
  logic [clex_pkg::KW_N-1:0]        kw_q, kw_d;
  logic [CNT_W-1:0]                 ident_cnt_q, ident_cnt_d;

  logic [clex_pkg::CHAR_W-1:0]      c;
  logic [3:0]                       dval;
  logic                             digit, name_char, name_start, space;
  logic                             cont_num, cont_name, starts_name, room;
  logic                             accept, push;
  clex_pkg::cmd_t                   cmd;

  assign c          = in_char_i;
  assign dval       = 4'(c - 8'h30);
  assign digit      = clex_pkg::is_digit(c);
  assign name_char  = clex_pkg::is_name_char(c);
  assign name_start = clex_pkg::is_name_start(c);
  assign space      = clex_pkg::is_space(c);

  assign cont_num    = (mode_q == MODE_NUMBER) && digit;
  assign cont_name   = (mode_q == MODE_NAME) && name_char;
  assign starts_name = name_start && (mode_q != MODE_NAME);
  assign room        = (len_q < LEN_W'(NAME_CAPACITY));

  // name buffer is shared: a new name waits for earlier identifier runs to drain
  assign in_ready_o = cmd_ready_i && !(starts_name && (ident_cnt_q != '0));
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd             = '0;
    cmd.flush_kind  = clex_pkg::KIND_IDENT;
    cmd.own_kind    = clex_pkg::KIND_UNKNOWN;
    cmd.has_flush   = ((mode_q == MODE_NUMBER) && !digit) || ((mode_q == MODE_NAME) && !name_char);
    if (mode_q == MODE_NUMBER) begin
      cmd.flush_kind  = clex_pkg::KIND_INTEGER;
      cmd.flush_value = acc_q;
    end else if (kw_q[clex_pkg::KW_INT] && (len_q == LEN_W'(3))) begin
      cmd.flush_kind = clex_pkg::KIND_KW_INT;
    end else if (kw_q[clex_pkg::KW_RETURN] && (len_q == LEN_W'(6))) begin
      cmd.flush_kind = clex_pkg::KIND_KW_RETURN;
    end else if (kw_q[clex_pkg::KW_IF] && (len_q == LEN_W'(2))) begin
      cmd.flush_kind = clex_pkg::KIND_KW_IF;
    end else if (kw_q[clex_pkg::KW_ELSE] && (len_q == LEN_W'(4))) begin
      cmd.flush_kind = clex_pkg::KIND_KW_ELSE;
    end
    cmd.flush_ident = (mode_q == MODE_NAME) && (cmd.flush_kind == clex_pkg::KIND_IDENT);
    cmd.has_own     = !cont_num && !cont_name && !space && !digit && !name_start;
    if (c == '0) begin
      cmd.own_kind = clex_pkg::KIND_EOF;
    end else begin
      cmd.own_kind = clex_pkg::symbol_kind(c);
    end
  end

  assign push        = accept && (cmd.has_flush || cmd.has_own);
  assign cmd_valid_o = push;
  assign cmd_o       = cmd;
  assign cmd_len_o   = len_q;

  assign wr_en_o   = accept && ((cont_name && room) || starts_name);
  assign wr_addr_o = starts_name ? '0 : len_q[IDX_W-1:0];
  assign wr_data_o = c;

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    len_d  = len_q;
    kw_d   = kw_q;
    if (accept) begin
      if (cont_num) begin
        acc_d = (acc_q << 3) + (acc_q << 1) + clex_pkg::VALUE_W'(dval);
      end else if (cont_name) begin
        if (room) begin
          len_d = len_q + 1'b1;
          kw_d  = kw_q & clex_pkg::kw_step(c, clex_pkg::KW_P_W'(len_q));
        end
      end else begin
        mode_d = MODE_IDLE;
        acc_d  = '0;
        len_d  = '0;
        if (digit) begin
          mode_d = MODE_NUMBER;
          acc_d  = clex_pkg::VALUE_W'(dval);
        end else if (name_start) begin
          mode_d = MODE_NAME;
          len_d  = LEN_W'(1);
          kw_d   = clex_pkg::kw_step(c, '0);
        end
      end
    end
    ident_cnt_d = ident_cnt_q + CNT_W'(push && cmd.flush_ident) - CNT_W'(ident_done_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      acc_q       <= '0;
      len_q       <= '0;
      kw_q        <= '0;
      ident_cnt_q <= '0;
    end else begin
      mode_q      <= mode_d;
      acc_q       <= acc_d;
      len_q       <= len_d;
      kw_q        <= kw_d;
      ident_cnt_q <= ident_cnt_d;
    end
  end

endmodule

/* rtl/core/clex_back.sv */
module clex_back #(
  parameter int NAME_CAPACITY = clex_pkg::NAME_CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  clex_pkg::cmd_t                     cmd_i,
  input  logic [$clog2(NAME_CAPACITY+1)-1:0] cmd_len_i,
  output logic                               ident_done_o,
  output logic [$clog2(NAME_CAPACITY)-1:0]   rd_addr_o,
  input  logic [clex_pkg::CHAR_W-1:0]        rd_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output clex_pkg::result_t                  out_o
);

  localparam int IDX_W = $clog2(NAME_CAPACITY);
  localparam int LEN_W = $clog2(NAME_CAPACITY + 1);

  typedef enum logic [1:0] {
    PH_FLUSH = 2'b01,
    PH_OWN   = 2'b10
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              out_valid_q;
  clex_pkg::result_t out_q, res;

  logic              load, fire, in_flush, last_char, flush_done, pop;

  assign load       = !out_valid_q || out_ready_i;
  assign fire       = cmd_valid_i && load;
  assign in_flush   = (phase_q == PH_FLUSH) && cmd_i.has_flush;
  assign last_char  = (LEN_W'(idx_q) == (cmd_len_i - 1'b1));
  assign flush_done = !cmd_i.flush_ident || last_char;
  assign pop        = fire && (!in_flush || (flush_done && !cmd_i.has_own));

  always_comb begin
    res             = '0;
    res.token_kind  = cmd_i.own_kind;
    res.text_end    = 1'b1;
    res.last_result = 1'b1;
    if (in_flush) begin
      res.last_result = flush_done && !cmd_i.has_own;
      if (cmd_i.flush_ident) begin
        res.token_kind    = clex_pkg::KIND_IDENT;
        res.text_char     = rd_data_i;
        res.text_position = clex_pkg::POS_W'(idx_q);
        res.text_end      = last_char;
      end else begin
        res.token_kind = cmd_i.flush_kind;
        res.int_value  = cmd_i.flush_value;
      end
    end
  end

  // read address is taken from idx_d so the registered rd_data_i always holds entry idx_q
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    if (fire) begin
      if (in_flush && !flush_done) begin
        idx_d = idx_q + 1'b1;
      end else if (in_flush && cmd_i.has_own) begin
        phase_d = PH_OWN;
        idx_d   = '0;
      end else begin
        phase_d = PH_FLUSH;
        idx_d   = '0;
      end
    end
  end

  assign rd_addr_o    = idx_d;
  assign cmd_ready_o  = pop;
  assign ident_done_o = pop && cmd_i.has_flush && cmd_i.flush_ident;
  assign out_valid_o  = out_valid_q;
  assign out_o        = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FLUSH;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      if (load) begin
        out_valid_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_CAP     = clex_pkg::NAME_CAPACITY_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_WORDS  = 108;

  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_NUMBER = 2'd1,
    SCAN_NAME   = 2'd2
  } scan_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;  // char_code
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;  // token_kind, int_value, text_char, text_position, text_end
  logic        m_axis_tlast;  // last_result

  c_subset_token_lexer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // lexer shadow state
  scan_e       scan_state = SCAN_IDLE;
  logic [31:0] number_sum = '0;
  logic [7:0]  name_chars [NAME_CAP];
  int          name_len = 0;

  clex_pkg::result_t pending_tokens[$];
  clex_pkg::result_t byte_tokens[$];

  int          mismatch_count = 0;
  int          words_sent = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_pct == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // outputs are stable from negedge up to the next rising edge
  always @(negedge clk_i) begin
    clex_pkg::result_t got;
    clex_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.token_kind    = clex_pkg::kind_e'(m_axis_tdata[4:0]);
      got.int_value     = m_axis_tdata[36:5];
      got.text_char     = m_axis_tdata[44:37];
      got.text_position = m_axis_tdata[49:45];
      got.text_end      = m_axis_tdata[50];
      got.last_result   = m_axis_tlast;
      if (pending_tokens.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: kind %0d value %0d char %0h pos %0d end %b last %b",
                   got.token_kind, got.int_value, got.text_char, got.text_position,
                   got.text_end, got.last_result);
      end else begin
        want = pending_tokens.pop_front();
        if (got.token_kind !== want.token_kind || got.int_value !== want.int_value ||
            got.text_char !== want.text_char || got.text_position !== want.text_position ||
            got.text_end !== want.text_end || got.last_result !== want.last_result) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: exp kind %0d value %0d char %0h pos %0d end %b last %b",
                      " / got kind %0d value %0d char %0h pos %0d end %b last %b"},
                     want.token_kind, want.int_value, want.text_char, want.text_position,
                     want.text_end, want.last_result, got.token_kind, got.int_value,
                     got.text_char, got.text_position, got.text_end, got.last_result);
        end
      end
    end
  end

  function automatic bit char_is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit char_starts_name(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit char_is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function void add_token(clex_pkg::kind_e k, logic [31:0] v, logic [7:0] ch,
                          logic [4:0] pos, logic e);
    clex_pkg::result_t t;
    t.token_kind    = k;
    t.int_value     = v;
    t.text_char     = ch;
    t.text_position = pos;
    t.text_end      = e;
    t.last_result   = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function bit name_matches(string w);
    if (name_len != w.len()) return 0;
    for (int i = 0; i < name_len; i++)
      if (name_chars[i] != w[i]) return 0;
    return 1;
  endfunction

  function void close_name();
    clex_pkg::kind_e k;
    k = clex_pkg::KIND_IDENT;
    if (name_matches("int"))         k = clex_pkg::KIND_KW_INT;
    else if (name_matches("return")) k = clex_pkg::KIND_KW_RETURN;
    else if (name_matches("if"))     k = clex_pkg::KIND_KW_IF;
    else if (name_matches("else"))   k = clex_pkg::KIND_KW_ELSE;
    if (k != clex_pkg::KIND_IDENT) begin
      add_token(k, '0, '0, '0, 1'b1);
    end else begin
      for (int i = 0; i < name_len; i++)
        add_token(clex_pkg::KIND_IDENT, '0, name_chars[i], 5'(i), (i + 1 == name_len));
    end
  endfunction

  function clex_pkg::kind_e single_char_kind(logic [7:0] c);
    case (c)
      "=":     return clex_pkg::KIND_ASSIGN;
      "+":     return clex_pkg::KIND_PLUS;
      "-":     return clex_pkg::KIND_MINUS;
      "*":     return clex_pkg::KIND_STAR;
      "/":     return clex_pkg::KIND_SLASH;
      "(":     return clex_pkg::KIND_LPAREN;
      ")":     return clex_pkg::KIND_RPAREN;
      "{":     return clex_pkg::KIND_LBRACE;
      "}":     return clex_pkg::KIND_RBRACE;
      ";":     return clex_pkg::KIND_SEMI;
      default: return clex_pkg::KIND_UNKNOWN;
    endcase
  endfunction

  function void lex_char(logic [7:0] c);
    byte_tokens.delete();
    if (scan_state == SCAN_NUMBER) begin
      if (char_is_digit(c)) begin
        number_sum = number_sum * 32'd10 + 32'(c - "0");
        return;
      end
      add_token(clex_pkg::KIND_INTEGER, number_sum, '0, '0, 1'b1);
      scan_state = SCAN_IDLE;
      number_sum = '0;
    end else if (scan_state == SCAN_NAME) begin
      if (char_starts_name(c) || char_is_digit(c)) begin
        if (name_len < NAME_CAP) begin
          name_chars[name_len] = c;
          name_len++;
        end
        return;
      end
      close_name();
      scan_state = SCAN_IDLE;
      name_len = 0;
    end

    if (c == 8'd0) begin
      add_token(clex_pkg::KIND_EOF, '0, '0, '0, 1'b1);
      scan_state = SCAN_IDLE;
      number_sum = '0;
      name_len = 0;
    end else if (char_is_blank(c)) begin
    end else if (char_is_digit(c)) begin
      scan_state = SCAN_NUMBER;
      number_sum = 32'(c - "0");
    end else if (char_starts_name(c)) begin
      scan_state = SCAN_NAME;
      name_chars[0] = c;
      name_len = 1;
    end else begin
      add_token(single_char_kind(c), '0, '0, '0, 1'b1);
    end

    if (byte_tokens.size() > 0) begin
      byte_tokens[byte_tokens.size() - 1].last_result = 1'b1;
      foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
    end
  endfunction

  task automatic send_char(logic [7:0] c);
    bit took;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    lex_char(c);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] rand_name_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] rand_name_start();
    logic [7:0] c;
    do c = rand_name_char(); while (char_is_digit(c));
    return c;
  endfunction

  task automatic send_random_token();
    int          r;
    int          len;
    string       kw[4] = '{"int", "return", "if", "else"};
    logic [7:0]  ops[10] = '{"=", "+", "-", "*", "/", "(", ")", "{", "}", ";"};
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_text(kw[$urandom_range(0, 3)]);
    end else if (r < 35) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
      send_char(rand_name_start());
      for (int i = 1; i < len; i++) send_char(rand_name_char());
    end else if (r < 55) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) send_char(8'("0" + $urandom_range(0, 9)));
    end else if (r < 80) begin
      send_char(ops[$urandom_range(0, 9)]);
    end else if (r < 85) begin
      send_char(8'($urandom_range(1, 255)));
    end else if (r < 90) begin
      send_char(8'($urandom_range(128, 255)));
    end else if (r < 93) begin
      send_char(8'd0);
    end else begin
      send_char(($urandom_range(0, 1) == 0) ? " " : 8'($urandom_range(9, 13)));
    end
    if ($urandom_range(0, 2) == 0) send_char(" ");
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_tokens();
    logic [7:0] seq[$] = '{"i", "f", "(", ")", "=", "+", "-", "*", "/", "{", "}", ";", " ",
                           "a", "_", "9", 8'hFF, "e", "l", "s", "e", 8'h09, "7", 8'h80,
                           8'h00};
    foreach (seq[i]) send_char(seq[i]);
    wait_drained();
  endtask

  task automatic test_random_source(int gap_pct, int hold_pct);
    int start;
    idle_pct  = gap_pct;
    stall_pct = hold_pct;
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) send_random_token();
    send_char(8'd0);
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_tokens();
    test_random_source(0, 0);
    test_random_source(55, 0);
    test_random_source(0, 55);
    test_random_source(33, 33);

    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0 && pending_tokens.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
